### rtl/haptic_spring_force_clamp_defines.svh
// Assertion macros shared by the spring force clamp RTL
`ifndef HAPTIC_SPRING_FORCE_CLAMP_DEFINES_SVH
`define HAPTIC_SPRING_FORCE_CLAMP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define HSFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsfc same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define HSFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsfc next-cycle check failed");

`endif

### rtl/hsfc_pkg.sv
// Types, constants and helpers of the spring force clamp
`default_nettype none
package hsfc_pkg;

    localparam int unsigned SQRT_STEPS = 17;
    localparam int unsigned DIV_STEPS  = 12;

    localparam logic signed [8:0] SCALE_AB = 9'sd180;
    localparam logic signed [7:0] SCALE_C  = 8'sd60;

    localparam logic signed [33:0] SAT_MAX = 34'sd8388607;
    localparam logic signed [33:0] SAT_MIN = -34'sd8388608;

    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_ORIGIN_Z      = 3'd2,
        REG_ORIGIN_ANGLES = 3'd3,
        REG_FORCE_GAIN    = 3'd4,
        REG_TORQUE_GAIN   = 3'd5,
        REG_CLAMP_RADIUS  = 3'd6,
        REG_FLOOR_Z_MODE  = 3'd7
    } hsfc_reg_t;

    // Per-sample data that rides along the root and divide chains
    typedef struct packed {
        logic signed [2:0][16:0] d;
        logic        [2:0][27:0] num;
        logic                    use_d;
        logic                    zero_r;
        logic signed [2:0][23:0] torque;
        logic signed [23:0]      shown_a;
        logic signed [23:0]      shown_b;
        logic signed [21:0]      shown_c;
    } hsfc_side_t;

    typedef struct packed {
        logic [34:0] rem;
        logic [34:0] root;
    } hsfc_sqrt_t;

    typedef struct packed {
        logic [2:0][27:0] rem;
        logic [2:0][11:0] quo;
        logic [16:0]      divisor;
    } hsfc_div_t;

    // Divide by 256 toward zero, then saturate to 24 bits
    function automatic logic signed [23:0] scale_sat(input logic signed [33:0] p);
        logic signed [33:0] q;
        q = (p + (p[33] ? 34'sd255 : 34'sd0)) >>> 8;
        if (q > SAT_MAX) begin
            return SAT_MAX[23:0];
        end
        if (q < SAT_MIN) begin
            return SAT_MIN[23:0];
        end
        return q[23:0];
    endfunction

endpackage
`default_nettype wire

### rtl/hsfc_sqrt_cell.sv
// One digit cell of the integer square root chain
`default_nettype none
module hsfc_sqrt_cell
    import hsfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [34:0] step_bit,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire hsfc_sqrt_t  up_data,
    input  wire hsfc_side_t  up_side,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output hsfc_sqrt_t       dn_data,
    output hsfc_side_t       dn_side
);

    logic       valid_reg;
    hsfc_sqrt_t data_reg, data_next;
    hsfc_side_t side_reg;
    logic [34:0] trial;

    always_comb
    begin
        trial = up_data.root + step_bit;
        if (up_data.rem >= trial)
        begin
            data_next.rem  = up_data.rem - trial;
            data_next.root = (up_data.root >> 1) + step_bit;
        end
        else
        begin
            data_next.rem  = up_data.rem;
            data_next.root = up_data.root >> 1;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign dn_side  = side_reg;

endmodule
`default_nettype wire

### rtl/hsfc_div_cell.sv
// One quotient-bit cell of the three-lane restoring divider chain
`default_nettype none
module hsfc_div_cell
    import hsfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [3:0] step_shift,
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wire hsfc_div_t  up_data,
    input  wire hsfc_side_t up_side,
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output hsfc_div_t       dn_data,
    output hsfc_side_t      dn_side
);

    logic       valid_reg;
    hsfc_div_t  data_reg, data_next;
    hsfc_side_t side_reg;
    logic [29:0] dsh;

    always_comb
    begin
        dsh = {13'd0, up_data.divisor} << step_shift;
        data_next = up_data;
        for (int i = 0; i < 3; i++)
        begin
            if ({2'b00, up_data.rem[i]} >= dsh)
            begin
                data_next.rem[i] = up_data.rem[i] - dsh[27:0];
                data_next.quo[i][step_shift] = 1'b1;
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign dn_side  = side_reg;

endmodule
`default_nettype wire

### rtl/haptic_spring_force_clamp.sv
// Top level of the haptic spring force clamp: config regs, pipeline and cell chains
//
//   channel | handshake         | payload
//   --------+-------------------+-------------------------------------------
//   in      | in_valid/in_ready | pos_x pos_y pos_z angle_a angle_b angle_c
//   out     | out_valid/out_ready | force_xyz torque_abc shown_angle_abc
//   config  | APB psel/penable  | paddr[5:3] picks register, pwdata 64 bits
//
// One transaction per cycle sustained while out_ready is high. Stages: 3 front,
// 17 square-root cells, 12 divide cells, 2 back stages incl. output reg.
// The root and divide cell chains set the latency, one digit per cell.
// Every stage advances on its own: a stalled output holds only the stages
// that are full, bubbles behind it still close up.
// Reset clears valid bits and loads config defaults; no clearing pass.
`default_nettype none
`include "haptic_spring_force_clamp_defines.svh"
module haptic_spring_force_clamp
    import hsfc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    input  wire logic signed [15:0] angle_a,
    input  wire logic signed [15:0] angle_b,
    input  wire logic signed [15:0] angle_c,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [23:0]      force_x,
    output logic signed [23:0]      force_y,
    output logic signed [23:0]      force_z,
    output logic signed [23:0]      torque_a,
    output logic signed [23:0]      torque_b,
    output logic signed [23:0]      torque_c,
    output logic signed [23:0]      shown_angle_a,
    output logic signed [23:0]      shown_angle_b,
    output logic signed [21:0]      shown_angle_c
);

    // ---------------- configuration registers ----------------
    logic signed [15:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [47:0]        origin_angles_reg;
    logic [15:0]        force_gain_reg, torque_gain_reg;
    logic [7:0]         clamp_radius_reg;
    logic               floor_z_mode_reg;
    hsfc_reg_t          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = hsfc_reg_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= 16'sd0;
            origin_y_reg      <= -16'sd480;
            origin_z_reg      <= -16'sd1280;
            origin_angles_reg <= 48'd0;
            force_gain_reg    <= 16'd256;
            torque_gain_reg   <= 16'd256;
            clamp_radius_reg  <= 8'd10;
            floor_z_mode_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_ORIGIN_X:      origin_x_reg      <= pwdata[15:0];
                REG_ORIGIN_Y:      origin_y_reg      <= pwdata[15:0];
                REG_ORIGIN_Z:      origin_z_reg      <= pwdata[15:0];
                REG_ORIGIN_ANGLES: origin_angles_reg <= pwdata[47:0];
                REG_FORCE_GAIN:    force_gain_reg    <= pwdata[15:0];
                REG_TORQUE_GAIN:   torque_gain_reg   <= pwdata[15:0];
                REG_CLAMP_RADIUS:  clamp_radius_reg  <= pwdata[7:0];
                REG_FLOOR_Z_MODE:  floor_z_mode_reg  <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ORIGIN_X:      prdata = {48'd0, origin_x_reg};
            REG_ORIGIN_Y:      prdata = {48'd0, origin_y_reg};
            REG_ORIGIN_Z:      prdata = {48'd0, origin_z_reg};
            REG_ORIGIN_ANGLES: prdata = {16'd0, origin_angles_reg};
            REG_FORCE_GAIN:    prdata = {48'd0, force_gain_reg};
            REG_TORQUE_GAIN:   prdata = {48'd0, torque_gain_reg};
            REG_CLAMP_RADIUS:  prdata = {56'd0, clamp_radius_reg};
            REG_FLOOR_Z_MODE:  prdata = {63'd0, floor_z_mode_reg};
            default:           prdata = 64'd0;
        endcase
    end

    // Clamp radius in Q.4
    logic [11:0] radius_q4;
    assign radius_q4 = {clamp_radius_reg, 4'b0000};

    // ---------------- stage A: differences ----------------
    logic                    a_vld_reg, a_rdy;
    logic signed [2:0][16:0] a_d_reg, a_adiff_reg;
    logic signed [2:0][15:0] a_ang_reg;
    logic signed [15:0]      org [3];
    logic signed [15:0]      pos [3];
    logic signed [15:0]      ang [3];
    logic signed [15:0]      tgt [3];

    assign org[0] = origin_x_reg;
    assign org[1] = origin_y_reg;
    assign org[2] = origin_z_reg;
    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;
    assign ang[0] = angle_a;
    assign ang[1] = angle_b;
    assign ang[2] = angle_c;
    assign tgt[0] = origin_angles_reg[15:0];
    assign tgt[1] = origin_angles_reg[31:16];
    assign tgt[2] = origin_angles_reg[47:32];

    assign in_ready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (a_rdy)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_d_reg[i]     <= {org[i][15], org[i]} - {pos[i][15], pos[i]};
                a_adiff_reg[i] <= {tgt[i][15], tgt[i]} - {ang[i][15], ang[i]};
                a_ang_reg[i]   <= ang[i];
            end
        end
    end

    // ---------------- stage B: products ----------------
    logic                    b_vld_reg, b_rdy;
    logic        [2:0][33:0] b_sq_reg;
    logic        [2:0][27:0] b_num_reg;
    logic signed [2:0][33:0] b_tprod_reg;
    logic signed [2:0][16:0] b_d_reg;
    logic signed [23:0]      b_shown_a_reg, b_shown_b_reg;
    logic signed [21:0]      b_shown_c_reg;
    logic        [16:0]      a_mag [3];
    logic signed [24:0]      shown_a_full, shown_b_full;
    logic signed [23:0]      shown_c_full;
    logic signed [33:0]      sq_full [3];
    logic        [28:0]      num_full [3];

    // Elements of a packed array select as unsigned: mark them signed again
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag[i]    = a_d_reg[i][16] ? 17'(-a_d_reg[i]) : 17'(a_d_reg[i]);
            sq_full[i]  = $signed(a_d_reg[i]) * $signed(a_d_reg[i]);
            num_full[i] = a_mag[i] * radius_q4;
        end
        shown_a_full = $signed(a_ang_reg[0]) * SCALE_AB;
        shown_b_full = $signed(a_ang_reg[1]) * SCALE_AB;
        shown_c_full = $signed(a_ang_reg[2]) * SCALE_C;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (b_rdy)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_rdy && a_vld_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i]    <= sq_full[i];
                b_num_reg[i]   <= num_full[i][27:0];
                b_tprod_reg[i] <= $signed(a_adiff_reg[i]) * $signed({1'b0, torque_gain_reg});
                b_d_reg[i]     <= a_d_reg[i];
            end
            b_shown_a_reg <= shown_a_full[23:0];
            b_shown_b_reg <= shown_b_full[23:0];
            b_shown_c_reg <= shown_c_full[21:0];
        end
    end

    // ---------------- stage C: sum, compare, torque ----------------
    logic        c_vld_reg, c_rdy;
    hsfc_sqrt_t  c_sqrt_reg;
    hsfc_side_t  c_side_reg, c_side_next;
    logic [34:0] sum_sq;
    logic [23:0] radius_sq;

    always_comb
    begin
        sum_sq    = 35'(b_sq_reg[0]) + 35'(b_sq_reg[1]) + 35'(b_sq_reg[2]);
        radius_sq = radius_q4 * radius_q4;
        c_side_next.d      = b_d_reg;
        c_side_next.num    = b_num_reg;
        c_side_next.use_d  = sum_sq < 35'(radius_sq);
        c_side_next.zero_r = (clamp_radius_reg == 8'd0);
        for (int i = 0; i < 3; i++)
        begin
            c_side_next.torque[i] = scale_sat(b_tprod_reg[i]);
        end
        c_side_next.shown_a = b_shown_a_reg;
        c_side_next.shown_b = b_shown_b_reg;
        c_side_next.shown_c = b_shown_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (c_rdy)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_rdy && b_vld_reg)
        begin
            c_sqrt_reg.rem  <= sum_sq;
            c_sqrt_reg.root <= 35'd0;
            c_side_reg      <= c_side_next;
        end
    end

    // ---------------- square root chain: one result bit per cell ----------------
    logic       sq_vld [SQRT_STEPS+1];
    logic       sq_rdy [SQRT_STEPS+1];
    hsfc_sqrt_t sq_dat [SQRT_STEPS+1];
    hsfc_side_t sq_side [SQRT_STEPS+1];

    assign sq_vld[0]  = c_vld_reg;
    assign sq_dat[0]  = c_sqrt_reg;
    assign sq_side[0] = c_side_reg;
    assign c_rdy      = !c_vld_reg || sq_rdy[0];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        hsfc_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_bit (35'd1 << (2 * (SQRT_STEPS - 1 - k))),
            .up_valid (sq_vld[k]),
            .up_ready (sq_rdy[k]),
            .up_data  (sq_dat[k]),
            .up_side  (sq_side[k]),
            .dn_valid (sq_vld[k+1]),
            .dn_ready (sq_rdy[k+1]),
            .dn_data  (sq_dat[k+1]),
            .dn_side  (sq_side[k+1])
        );
    end

    // ---------------- divide chain: one quotient bit per cell ----------------
    logic       dv_vld [DIV_STEPS+1];
    logic       dv_rdy [DIV_STEPS+1];
    hsfc_div_t  dv_dat [DIV_STEPS+1];
    hsfc_side_t dv_side [DIV_STEPS+1];

    assign dv_vld[0]      = sq_vld[SQRT_STEPS];
    assign sq_rdy[SQRT_STEPS] = dv_rdy[0];
    assign dv_side[0]     = sq_side[SQRT_STEPS];
    assign dv_dat[0].rem  = sq_side[SQRT_STEPS].num;
    assign dv_dat[0].quo  = '0;
    assign dv_dat[0].divisor = sq_dat[SQRT_STEPS].root[16:0];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        hsfc_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .step_shift (4'(DIV_STEPS - 1 - k)),
            .up_valid   (dv_vld[k]),
            .up_ready   (dv_rdy[k]),
            .up_data    (dv_dat[k]),
            .up_side    (dv_side[k]),
            .dn_valid   (dv_vld[k+1]),
            .dn_ready   (dv_rdy[k+1]),
            .dn_data    (dv_dat[k+1]),
            .dn_side    (dv_side[k+1])
        );
    end

    // ---------------- stage F: pick vector, times force gain ----------------
    logic                    f_vld_reg, f_rdy;
    logic signed [2:0][33:0] f_prod_reg;
    hsfc_side_t              f_side_reg;
    hsfc_side_t              dv_last;
    logic signed [16:0]      vec [3];

    assign dv_last = dv_side[DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_last.use_d)
            begin
                vec[i] = dv_last.d[i];
            end
            else if (dv_last.zero_r)
            begin
                vec[i] = 17'sd0;
            end
            else if (dv_last.d[i][16])
            begin
                vec[i] = -$signed({5'd0, dv_dat[DIV_STEPS].quo[i]});
            end
            else
            begin
                vec[i] = $signed({5'd0, dv_dat[DIV_STEPS].quo[i]});
            end
        end
    end

    assign dv_rdy[DIV_STEPS] = f_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (f_rdy)
        begin
            f_vld_reg <= dv_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy && dv_vld[DIV_STEPS])
        begin
            for (int i = 0; i < 3; i++)
            begin
                f_prod_reg[i] <= vec[i] * $signed({1'b0, force_gain_reg});
            end
            f_side_reg <= dv_last;
        end
    end

    // ---------------- stage G: scale, saturate, floor; output register ----------------
    logic               g_vld_reg, g_rdy;
    logic signed [23:0] g_fx_reg, g_fy_reg, g_fz_reg;
    hsfc_side_t         g_side_reg;
    logic signed [23:0] fz_sat;

    assign fz_sat = scale_sat(f_prod_reg[2]);

    assign g_rdy = !g_vld_reg || out_ready;
    assign f_rdy = !f_vld_reg || g_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
        end
        else if (g_rdy)
        begin
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_rdy && f_vld_reg)
        begin
            g_fx_reg   <= scale_sat(f_prod_reg[0]);
            g_fy_reg   <= scale_sat(f_prod_reg[1]);
            // drop a pull below the floor when the mode asks for it
            g_fz_reg   <= (floor_z_mode_reg && fz_sat[23]) ? 24'sd0 : fz_sat;
            g_side_reg <= f_side_reg;
        end
    end

    // Ready ripples back through the front stages
    assign b_rdy = !b_vld_reg || c_rdy;
    assign a_rdy = !a_vld_reg || b_rdy;

    assign out_valid     = g_vld_reg;
    assign force_x       = g_fx_reg;
    assign force_y       = g_fy_reg;
    assign force_z       = g_fz_reg;
    assign torque_a      = g_side_reg.torque[0];
    assign torque_b      = g_side_reg.torque[1];
    assign torque_c      = g_side_reg.torque[2];
    assign shown_angle_a = g_side_reg.shown_a;
    assign shown_angle_b = g_side_reg.shown_b;
    assign shown_angle_c = g_side_reg.shown_c;

    // ---------------- checks ----------------
    `HSFC_ASSERT_IMP(a_floor_holds, out_valid && floor_z_mode_reg, !force_z[23])
    `HSFC_ASSERT_IMP(a_quo_in_radius,
        dv_vld[DIV_STEPS] && !dv_last.use_d && !dv_last.zero_r,
        dv_dat[DIV_STEPS].quo[0] <= radius_q4 && dv_dat[DIV_STEPS].quo[1] <= radius_q4
        && dv_dat[DIV_STEPS].quo[2] <= radius_q4)
    `HSFC_ASSERT_IMP(a_full_when_blocked, !in_ready, out_valid && !out_ready)
    `HSFC_ASSERT_NXT(a_accept_lands, in_valid && in_ready, a_vld_reg)

endmodule
`default_nettype wire
